// ===== rtl/core/tgi_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the gap interpolator.
package tgi_pkg;

  localparam int MAX_GAP       = 64;
  localparam int TABLE_ENTRIES = 256;
  localparam int SAMPLE_W      = 16;
  localparam int GAP_W         = 7;
  localparam int STATUS_W      = 2;
  localparam int TRIG_W        = 17;                              // Q16 magnitude, 0..65536
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int PHASE_W       = $clog2(2 * TABLE_ENTRIES + 1);
  localparam int ONE_Q16       = 65536;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       left_present;
    logic                       right_present;
    logic [GAP_W-1:0]           gap_length;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [STATUS_W-1:0]        status;
    logic                       last;
  } out_item_t;

  // quotient and remainder of the phase step division
  typedef struct packed {
    logic [PHASE_W-1:0] quot;
    logic [GAP_W-1:0]   rem;
  } div_res_t;

  typedef logic [TRIG_W-1:0] qsin_tbl_t [TABLE_ENTRIES+1];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DEN [1:8] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};

  // sin((pi/2)*i/TABLE_ENTRIES) in Q16, Taylor series through x^17 in Q30
  function automatic qsin_tbl_t build_qsin();
    qsin_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= TABLE_ENTRIES; i++) begin
      x    = (64'(i) * HALF_PI_Q30) / TABLE_ENTRIES;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DEN[n];
        if ((n & 1) != 0) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      sum = (sum + 64'd8192) >> 14;
      if (sum > 64'(ONE_Q16)) begin
        sum = 64'(ONE_Q16);
      end
      tbl[i] = sum[TRIG_W-1:0];
    end
    return tbl;
  endfunction

  localparam qsin_tbl_t QSIN_TBL = build_qsin();

endpackage

// ===== rtl/core/trig_gap_interpolator_top.sv =====
// Top level of the cosine/sine gap interpolator: sequencer, phase stepper, lookup and blend.
//
// Fills a gap of N samples (gap_length, saturated to 64) between left_sample and
// right_sample, Q1.15. Sample k of N blends left*(1-r) + right*r, with
// r = (1 - trig(pi*k/(N+1)))/2 taken from a 257-entry quarter-wave sine table,
// rounded half up and saturated. start is taken while busy is low; for a normal item
// busy then stays high until the last word of the item is out. A normal item passes
// through S_DIV, where the bit-serial divider finds 2*TABLE_ENTRIES/(N+1) once, then
// S_INIT for setup, then per sample S_LOOK (table read), S_MUL (multiply) and S_OUT
// (round, saturate and phase step) around the one shared multiplier. An item with a
// missing neighbour or a zero gap gives one word the cycle after start and the
// block is free again at once. Result words appear on out_item for exactly one
// cycle with out_valid high; there is no backpressure, so the receiver must take
// every word when it comes. curve_mode (reset 1 = cosine, 0 = sine) is written
// through cfg_valid/cfg_ready/cfg_data; cfg_ready is high whenever busy is low.

module trig_gap_interpolator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  tgi_pkg::in_item_t  in_item,
  output logic               out_valid,
  output tgi_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import tgi_pkg::*;

  localparam int PROD_W = SAMPLE_W + 1 + TRIG_W + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam int SHR_W  = ACC_W - 16;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_LOOK = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic                        mode_r;
  logic                        out_valid_r;
  out_item_t                   out_item_r;

  logic signed [SAMPLE_W-1:0]  left_r;
  logic signed [SAMPLE_W:0]    diff_r;
  logic [GAP_W-1:0]            n_r;
  logic [GAP_W-1:0]            den_r;
  logic [GAP_W-1:0]            k_r;
  logic [PHASE_W-1:0]          q0_r;
  logic [GAP_W-1:0]            r0_r;
  logic [PHASE_W-1:0]          phase_r;
  logic [GAP_W-1:0]            prem_r;
  logic [TRIG_W-1:0]           ratio_r;
  logic signed [PROD_W-1:0]    prod_r;

  logic                        accept;
  logic                        bad_item;
  logic [GAP_W-1:0]            n_sat;
  logic                        div_done;
  div_res_t                    div_res;

  // phase stepper: p_k = floor((2*T*k + floor(d/2)) / d) kept as quotient + remainder
  logic [PHASE_W-1:0]          base_ph;
  logic [GAP_W-1:0]            base_rem;
  logic [GAP_W:0]              rsum;
  logic                        wrap;
  logic [PHASE_W-1:0]          ph_step;
  logic [GAP_W-1:0]            rem_step;

  // table lookup
  logic                        low_half;
  logic [PHASE_W-1:0]          idx_w;
  logic                        neg;
  logic [TRIG_W-1:0]           mag;
  logic signed [TRIG_W:0]      trig_s;
  logic signed [TRIG_W+1:0]    two_r;

  // blend, round, saturate
  logic signed [PROD_W-1:0]    prod_nxt;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SHR_W-1:0]     shr;
  logic signed [SAMPLE_W-1:0]  sat;

  assign accept    = start && !busy;
  assign bad_item  = !in_item.left_present || !in_item.right_present ||
                     (in_item.gap_length == '0);
  assign n_sat     = (in_item.gap_length > GAP_W'(MAX_GAP)) ? GAP_W'(MAX_GAP)
                                                            : in_item.gap_length;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;

  tgi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && !bad_item),
    .dividend (PHASE_W'(2 * TABLE_ENTRIES)),
    .divisor  (n_sat + 1'b1),
    .done     (div_done),
    .res      (div_res)
  );

  always_comb begin
    if (state_r == S_INIT) begin
      base_ph  = '0;
      base_rem = den_r >> 1;
    end else begin
      base_ph  = phase_r;
      base_rem = prem_r;
    end
    rsum     = {1'b0, base_rem} + {1'b0, r0_r};
    wrap     = (rsum >= {1'b0, den_r});
    ph_step  = base_ph + q0_r + PHASE_W'(wrap);
    rem_step = wrap ? GAP_W'(rsum - {1'b0, den_r}) : rsum[GAP_W-1:0];
  end

  // fold the half-wave phase onto the quarter table
  always_comb begin
    low_half = (phase_r <= PHASE_W'(TABLE_ENTRIES));
    if (mode_r) begin
      idx_w = low_half ? PHASE_W'(TABLE_ENTRIES) - phase_r
                       : phase_r - PHASE_W'(TABLE_ENTRIES);
      neg   = !low_half;
    end else begin
      idx_w = low_half ? phase_r : PHASE_W'(2 * TABLE_ENTRIES) - phase_r;
      neg   = 1'b0;
    end
    mag    = QSIN_TBL[idx_w[TBL_IDX_W-1:0]];
    trig_s = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    two_r  = (TRIG_W+2)'(ONE_Q16 + 1) - {trig_s[TRIG_W], trig_s};
  end

  // acc = left*2^16 + (right-left)*r, then floor((acc + 2^15) / 2^16)
  always_comb begin
    prod_nxt = diff_r * $signed({1'b0, ratio_r});
    acc      = $signed({{(ACC_W-SAMPLE_W-16){left_r[SAMPLE_W-1]}}, left_r, 16'b0})
             + $signed({prod_r[PROD_W-1], prod_r})
             + $signed(ACC_W'(32768));
    shr      = acc[ACC_W-1:16];
    if (shr > $signed(SHR_W'(32767))) begin
      sat = 16'sh7fff;
    end else if (shr < -$signed(SHR_W'(32768))) begin
      sat = 16'sh8000;
    end else begin
      sat = shr[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !bad_item) begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: state_nxt = S_LOOK;
      S_LOOK: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT: begin
        state_nxt = (k_r == n_r) ? S_IDLE : S_LOOK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && bad_item) || (state_r == S_OUT);
      if (cfg_valid && cfg_ready) begin
        mode_r <= cfg_data;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      left_r <= in_item.left_sample;
      diff_r <= $signed({in_item.right_sample[SAMPLE_W-1], in_item.right_sample})
              - $signed({in_item.left_sample[SAMPLE_W-1], in_item.left_sample});
      n_r    <= n_sat;
      den_r  <= n_sat + 1'b1;
      k_r    <= GAP_W'(1);
      if (!in_item.left_present || !in_item.right_present) begin
        out_item_r <= '{sample: '0, status: ST_MISS, last: 1'b1};
      end else if (in_item.gap_length == '0) begin
        out_item_r <= '{sample: '0, status: ST_EMPTY, last: 1'b1};
      end
    end
    if (state_r == S_DIV && div_done) begin
      q0_r <= div_res.quot;
      r0_r <= div_res.rem;
    end
    if (state_r == S_INIT) begin
      phase_r <= ph_step;
      prem_r  <= rem_step;
    end
    if (state_r == S_LOOK) begin
      ratio_r <= two_r[TRIG_W:1];
    end
    if (state_r == S_MUL) begin
      prod_r <= prod_nxt;
    end
    if (state_r == S_OUT) begin
      out_item_r <= '{sample: sat, status: ST_OK, last: (k_r == n_r)};
      phase_r    <= ph_step;
      prem_r     <= rem_step;
      k_r        <= k_r + 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/tgi_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-item phase step.
module tgi_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tgi_pkg::PHASE_W-1:0] dividend,
  input  logic [tgi_pkg::GAP_W-1:0]   divisor,
  output logic                       done,
  output tgi_pkg::div_res_t          res
);
  import tgi_pkg::*;

  localparam int CNT_W = $clog2(PHASE_W + 1);

  logic               run_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PHASE_W-1:0] quot_r;
  logic [GAP_W-1:0]   rem_r;
  logic [GAP_W-1:0]   div_r;

  logic [GAP_W:0]     trial;
  logic               ge;
  logic [GAP_W-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, quot_r[PHASE_W-1]};
    ge      = (trial >= {1'b0, div_r});
    rem_nxt = ge ? GAP_W'(trial - {1'b0, div_r}) : trial[GAP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(PHASE_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot_r <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (run_r) begin
      quot_r <= {quot_r[PHASE_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule
